>>> sv/assert_macros.svh
// Assertion macros for the checker of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define MFSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Condition in one cycle that implies a condition in the next cycle.
`define MFSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/mfsc_pkg.sv
package mfsc_pkg;

    // Width of the confusion counters.
    localparam int COUNT_BITS = 24;
    // Width of the count fields in a result.
    localparam int OUT_CNT_BITS = 24;
    // Quotient bits of the Q0.16 score.
    localparam int QUO_BITS = 16;
    localparam int STEP_BITS = $clog2(QUO_BITS);

    // Gray levels for foreground and background.
    localparam logic [7:0] GRAY_FG = 8'd0;
    localparam logic [7:0] GRAY_BG = 8'd255;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    typedef struct packed {
        logic [7:0] mask_pixel;
        logic [7:0] predicted_pixel;
        logic [7:0] target_pixel;
        logic       last_pixel;
        logic [7:0] individual_tag;
    } mfsc_in_t;

    typedef struct packed {
        logic [QUO_BITS-1:0]     f1_frac;
        logic [OUT_CNT_BITS-1:0] true_pos;
        logic [OUT_CNT_BITS-1:0] false_pos;
        logic [OUT_CNT_BITS-1:0] false_neg;
        logic [7:0]              result_tag;
    } mfsc_out_t;

    // Saturating increment of a counter.
    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // A zero count is reported as one.
    function automatic logic [COUNT_BITS-1:0] bump_zero(input logic [COUNT_BITS-1:0] c);
        return (c == '0) ? {{(COUNT_BITS-1){1'b0}}, 1'b1} : c;
    endfunction

    // Fit a counter into the result count width.
    function automatic logic [OUT_CNT_BITS-1:0] to_out(input logic [COUNT_BITS-1:0] c);
        logic [COUNT_BITS+OUT_CNT_BITS-1:0] w;
        w = {{OUT_CNT_BITS{1'b0}}, c};
        return w[OUT_CNT_BITS-1:0];
    endfunction

endpackage

>>> sv/masked_f1_score_counter.sv
// Channel  | Handshake           | Payload     | Direction
// ---------+---------------------+-------------+----------
// pixel    | in_valid / in_ready | in_data     | input
// result   | out_valid/out_ready | out_data    | output
//
// A pixel without the last mark is counted as it is taken; pixels stream back to back while no score is in progress.
// A last pixel starts the score: a setup state, the divider state (one quotient bit
// per cycle) and a final state that loads the result register, during which
// in_ready is low.
// A held score does not stop pixels; a new score waits in its final state until the held score is taken.
// Reset (rst_n, asynchronous, active low) clears the counters and the sequencer.
module masked_f1_score_counter
    import mfsc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  mfsc_in_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output mfsc_out_t out_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SETUP = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_FIN   = 2'd3;

    localparam int DEN_BITS = COUNT_BITS + 2;

    logic [1:0]            state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;
    logic [COUNT_BITS-1:0] tp_reg, tp_next, fp_reg, fp_next, fn_reg, fn_next;
    logic [COUNT_BITS-1:0] tp_res_reg, tp_res_next, fp_res_reg, fp_res_next;
    logic [COUNT_BITS-1:0] fn_res_reg, fn_res_next;
    logic [7:0]            tag_reg, tag_next;
    logic [DEN_BITS-1:0]   den_reg, den_next, rem_reg, rem_next;
    logic [QUO_BITS-1:0]   quo_reg, quo_next;
    logic                  out_valid_reg, out_valid_next;
    mfsc_out_t             out_reg, out_next;

    logic                  accept;
    logic                  is_tp, is_fp, is_fn;
    logic [COUNT_BITS-1:0] tp_upd, fp_upd, fn_upd;
    logic [DEN_BITS:0]     shifted, den_ext, diff;
    logic                  ge;
    logic                  out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Classify the pixel and form the updated counts.
    always_comb
    begin
        is_tp  = (in_data.mask_pixel != 8'd0) && (in_data.predicted_pixel == GRAY_FG)
                 && (in_data.target_pixel == GRAY_FG);
        is_fp  = (in_data.mask_pixel != 8'd0) && (in_data.predicted_pixel == GRAY_FG)
                 && (in_data.target_pixel == GRAY_BG);
        is_fn  = (in_data.mask_pixel != 8'd0) && (in_data.predicted_pixel == GRAY_BG)
                 && (in_data.target_pixel == GRAY_FG);
        tp_upd = is_tp ? sat_inc(tp_reg) : tp_reg;
        fp_upd = is_fp ? sat_inc(fp_reg) : fp_reg;
        fn_upd = is_fn ? sat_inc(fn_reg) : fn_reg;
    end

    // Restoring divider step: shift the remainder and trial-subtract the divisor.
    always_comb
    begin
        shifted = {rem_reg, 1'b0};
        den_ext = {1'b0, den_reg};
        diff    = shifted - den_ext;
        ge      = (shifted >= den_ext);
    end

    // Sequencer and datapath next values.
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        tp_next        = tp_reg;
        fp_next        = fp_reg;
        fn_next        = fn_reg;
        tp_res_next    = tp_res_reg;
        fp_res_next    = fp_res_reg;
        fn_res_next    = fn_res_reg;
        tag_next       = tag_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.last_pixel)
                    begin
                        tp_res_next = bump_zero(tp_upd);
                        fp_res_next = bump_zero(fp_upd);
                        fn_res_next = bump_zero(fn_upd);
                        tag_next    = in_data.individual_tag;
                        tp_next     = '0;
                        fp_next     = '0;
                        fn_next     = '0;
                        state_next  = ST_SETUP;
                    end
                    else
                    begin
                        tp_next = tp_upd;
                        fp_next = fp_upd;
                        fn_next = fn_upd;
                    end
                end
            end
            ST_SETUP:
            begin
                // Numerator 2tp and divisor 2tp + fp + fn.
                rem_next   = {1'b0, tp_res_reg, 1'b0};
                den_next   = {1'b0, tp_res_reg, 1'b0} + {2'b00, fp_res_reg}
                             + {2'b00, fn_res_reg};
                quo_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
                quo_next = {quo_reg[QUO_BITS-2:0], ge};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_BITS'(QUO_BITS - 1))
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_next.f1_frac    = quo_reg;
                    out_next.true_pos   = to_out(tp_res_reg);
                    out_next.false_pos  = to_out(fp_res_reg);
                    out_next.false_neg  = to_out(fn_res_reg);
                    out_next.result_tag = tag_reg;
                    out_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            tp_reg        <= '0;
            fp_reg        <= '0;
            fn_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            tp_reg        <= tp_next;
            fp_reg        <= fp_next;
            fn_reg        <= fn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        tp_res_reg <= tp_res_next;
        fp_res_reg <= fp_res_next;
        fn_res_reg <= fn_res_next;
        tag_reg    <= tag_next;
        den_reg    <= den_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        out_reg    <= out_next;
    end

endmodule

>>> sv/mfsc_checker.sv
`include "assert_macros.svh"

module mfsc_checker
    import mfsc_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input mfsc_in_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input mfsc_out_t out_data
);

    logic out_stalled;
    logic last_taken;
    logic counts_ok;

    assign out_stalled = out_valid && !out_ready;
    assign last_taken  = in_valid && in_ready && in_data.last_pixel;
    assign counts_ok   = (out_data.true_pos != '0) && (out_data.false_pos != '0)
                         && (out_data.false_neg != '0);

    // A stalled result request stays valid and keeps its payload.
    `MFSC_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_stalled, out_valid, "result dropped")
    `MFSC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stalled, $stable(out_data), "result changed")

    // A last pixel starts the score, so no pixel is taken in the next cycle.
    `MFSC_ASSERT_NEXT(a_busy_after_last, clk, rst_n, last_taken, !in_ready, "taken while busy")

    // Reported counts are never zero after the bump.
    `MFSC_ASSERT(a_counts_nonzero, clk, rst_n, !out_valid || counts_ok, "zero count in result")

endmodule

bind masked_f1_score_counter mfsc_checker u_mfsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

>>> tb/masked_f1_score_counter_test.sv
module masked_f1_score_counter_test;
    import mfsc_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 220;
    localparam int MAX_REPORTS = 10;
    // Sender idle and receiver stall percentages for each pacing phase.
    localparam int SEND_IDLE [4] = '{0, 58, 0, 19};
    localparam int RECV_STALL [4] = '{0, 0, 58, 19};
    // Pixel kind mix for each image profile: balanced, mostly hits, mostly
    // errors, mostly pixels that change no counter. Each row sums to 100.
    localparam int PIXEL_MIX [4][6] = '{'{30, 20, 20, 10, 10, 10},
                                        '{85,  5,  5,  0,  5,  0},
                                        '{ 5, 45, 45,  0,  5,  0},
                                        '{ 5,  5,  5, 30, 30, 25}};

    typedef enum int {PX_TP, PX_FP, PX_FN, PX_BGBG, PX_OTHER, PX_NEAR} pixel_kind_e;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid = 1'b0;
    logic      in_ready;
    mfsc_in_t  in_data = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    mfsc_out_t out_data;

    // Requests waiting to be driven and scores waiting to be seen.
    mfsc_in_t  pixel_q[$];
    mfsc_out_t score_exp_q[$];

    // Confusion counts of the image that is being streamed.
    logic [COUNT_BITS-1:0] tp_acc = '0;
    logic [COUNT_BITS-1:0] fp_acc = '0;
    logic [COUNT_BITS-1:0] fn_acc = '0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_off = 1'b0;
    int mismatches = 0;
    int pixels_sent = 0;
    int scores_checked = 0;
    int cycle_count = 0;
    mfsc_out_t want;

    masked_f1_score_counter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Count one accepted pixel and, on the last pixel, work out the score.
    task automatic count_pixel(input mfsc_in_t px);
        mfsc_out_t             sc;
        logic [COUNT_BITS-1:0] tp;
        logic [COUNT_BITS-1:0] fp;
        logic [COUNT_BITS-1:0] fn;
        logic [63:0]           num;
        logic [63:0]           den;
        logic [63:0]           quo;
        pixels_sent++;
        if (px.mask_pixel != 8'd0)
        begin
            if (px.predicted_pixel == GRAY_FG && px.target_pixel == GRAY_FG)
                tp_acc = (tp_acc == CNT_MAX) ? tp_acc : tp_acc + 1'b1;
            else if (px.predicted_pixel == GRAY_FG && px.target_pixel == GRAY_BG)
                fp_acc = (fp_acc == CNT_MAX) ? fp_acc : fp_acc + 1'b1;
            else if (px.predicted_pixel == GRAY_BG && px.target_pixel == GRAY_FG)
                fn_acc = (fn_acc == CNT_MAX) ? fn_acc : fn_acc + 1'b1;
        end
        if (px.last_pixel)
        begin
            // Zero counts are reported as one, so the divisor is never zero.
            tp = (tp_acc == '0) ? COUNT_BITS'(1) : tp_acc;
            fp = (fp_acc == '0) ? COUNT_BITS'(1) : fp_acc;
            fn = (fn_acc == '0) ? COUNT_BITS'(1) : fn_acc;
            num = 64'(tp) << 17;
            den = (64'(tp) << 1) + 64'(fp) + 64'(fn);
            quo = num / den;
            if (quo > 64'hFFFF)
                quo = 64'hFFFF;
            sc.f1_frac = quo[QUO_BITS-1:0];
            sc.true_pos = OUT_CNT_BITS'(tp);
            sc.false_pos = OUT_CNT_BITS'(fp);
            sc.false_neg = OUT_CNT_BITS'(fn);
            sc.result_tag = px.individual_tag;
            score_exp_q.push_back(sc);
            tp_acc = '0;
            fp_acc = '0;
            fn_acc = '0;
        end
    endtask

    task automatic note_mismatch(input string field, input longint unsigned want_v,
                                 input longint unsigned got_v);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("score %0d: %s expected %0d, got %0d", scores_checked, field, want_v, got_v);
    endtask

    function automatic void push_px(input logic [7:0] mask, input logic [7:0] pred,
                                    input logic [7:0] targ, input logic last,
                                    input logic [7:0] tag);
        mfsc_in_t px;
        px.mask_pixel = mask;
        px.predicted_pixel = pred;
        px.target_pixel = targ;
        px.last_pixel = last;
        px.individual_tag = tag;
        pixel_q.push_back(px);
    endfunction

    // Queue one image of random pixels and return its length.
    function automatic int queue_image();
        int          len;
        int          profile;
        int          cut;
        int          k;
        int          acc;
        int          r;
        logic [7:0]  mask;
        logic [7:0]  pred;
        logic [7:0]  targ;
        r = $urandom_range(99);
        if (r < 2)
            len = $urandom_range(500, 200);
        else if (r < 20)
            len = $urandom_range(3, 1);
        else
            len = $urandom_range(40, 4);
        profile = $urandom_range(3);
        for (int i = 0; i < len; i++)
        begin
            cut = $urandom_range(99);
            k = 0;
            acc = PIXEL_MIX[profile][0];
            while (cut >= acc)
            begin
                k++;
                acc += PIXEL_MIX[profile][k];
            end
            case (pixel_kind_e'(k))
                PX_TP:    begin pred = GRAY_FG; targ = GRAY_FG; end
                PX_FP:    begin pred = GRAY_FG; targ = GRAY_BG; end
                PX_FN:    begin pred = GRAY_BG; targ = GRAY_FG; end
                PX_BGBG:  begin pred = GRAY_BG; targ = GRAY_BG; end
                PX_OTHER:
                begin
                    pred = 8'($urandom_range(255));
                    targ = 8'($urandom_range(255));
                end
                default:
                begin
                    // Values at or one step away from the two gray levels.
                    pred = 8'($urandom_range(1));
                    if ($urandom_range(1) != 0)
                        pred = ~pred;
                    targ = 8'($urandom_range(1));
                    if ($urandom_range(1) != 0)
                        targ = ~targ;
                end
            endcase
            r = $urandom_range(15);
            if (r < 2)
                mask = 8'd0;
            else if (r == 2)
                mask = 8'd255;
            else if (r == 3)
                mask = 8'd1;
            else
                mask = 8'($urandom_range(255, 1));
            push_px(mask, pred, targ, i == len - 1, 8'($urandom_range(255)));
        end
        return len;
    endfunction

    // Driver: present queued requests, holding each one until it is taken.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                count_pixel(in_data);
            if (!in_valid || in_ready)
            begin
                if (!hold_off && pixel_q.size() != 0 &&
                    $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pixel_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each taken score against the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (score_exp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected score %0d with tag %0d",
                                 out_data.f1_frac, out_data.result_tag);
                end
                else
                begin
                    want = score_exp_q.pop_front();
                    if (out_data.f1_frac !== want.f1_frac)
                        note_mismatch("f1_frac", want.f1_frac, out_data.f1_frac);
                    if (out_data.true_pos !== want.true_pos)
                        note_mismatch("true_pos", want.true_pos, out_data.true_pos);
                    if (out_data.false_pos !== want.false_pos)
                        note_mismatch("false_pos", want.false_pos, out_data.false_pos);
                    if (out_data.false_neg !== want.false_neg)
                        note_mismatch("false_neg", want.false_neg, out_data.false_neg);
                    if (out_data.result_tag !== want.result_tag)
                        note_mismatch("result_tag", want.result_tag, out_data.result_tag);
                    scores_checked++;
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("masked_f1_score_counter regression: fail");
            $finish;
        end
    end

    initial
    begin
        int queued;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // A last pixel that is masked out, with every count still zero.
        push_px(8'd0, GRAY_FG, GRAY_FG, 1'b1, 8'h00);
        // A single true positive that is also the last pixel.
        push_px(8'd255, GRAY_FG, GRAY_FG, 1'b1, 8'hFF);
        // Each counted event at least once, with small and large mask values.
        push_px(8'd1, GRAY_FG, GRAY_FG, 1'b0, 8'h12);
        push_px(8'd255, GRAY_FG, GRAY_FG, 1'b0, 8'h34);
        push_px(8'd128, GRAY_FG, GRAY_BG, 1'b0, 8'h56);
        push_px(8'd255, GRAY_BG, GRAY_FG, 1'b0, 8'h78);
        push_px(8'd7, GRAY_FG, GRAY_FG, 1'b1, 8'hA5);
        // Pairs that change no counter, and counted pairs under a zero mask.
        push_px(8'd255, 8'd0, 8'd1, 1'b0, 8'h00);
        push_px(8'd255, 8'd1, 8'd0, 1'b0, 8'hFF);
        push_px(8'd255, 8'd255, 8'd254, 1'b0, 8'h00);
        push_px(8'd255, 8'd254, 8'd255, 1'b0, 8'hFF);
        push_px(8'd255, GRAY_BG, GRAY_BG, 1'b0, 8'h00);
        push_px(8'd0, GRAY_FG, GRAY_BG, 1'b0, 8'hFF);
        push_px(8'd0, GRAY_BG, GRAY_FG, 1'b0, 8'h00);
        push_px(8'd255, 8'd128, 8'd128, 1'b1, 8'h5A);
        // An image of errors only, so the true positive count is bumped.
        for (int i = 0; i < 3; i++)
            push_px(8'd255, GRAY_FG, GRAY_BG, 1'b0, 8'h0F);
        for (int i = 0; i < 2; i++)
            push_px(8'd255, GRAY_BG, GRAY_FG, 1'b0, 8'hF0);
        push_px(8'd1, GRAY_FG, GRAY_BG, 1'b1, 8'h3C);
        // An image of hits only, so both error counts are bumped.
        for (int i = 0; i < 3; i++)
            push_px(8'd255, GRAY_FG, GRAY_FG, 1'b0, 8'hC3);
        push_px(8'd255, GRAY_FG, GRAY_FG, 1'b1, 8'h01);

        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            send_idle_pct = SEND_IDLE[phase];
            recv_stall_pct = RECV_STALL[phase];
            queued = 0;
            while (queued < PHASE_ITEMS / 2)
                queued += queue_image();
            if (phase == 2)
            begin
                // Let the pipe drain completely before the second half.
                while (pixel_q.size() != 0)
                    @(negedge clk);
                hold_off = 1'b1;
                while (in_valid || score_exp_q.size() != 0)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            while (queued < PHASE_ITEMS)
                queued += queue_image();
            while (pixel_q.size() != 0 || in_valid)
                @(negedge clk);
        end

        while (pixel_q.size() != 0 || in_valid || score_exp_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        $display("Streamed %0d pixels and checked %0d scores across four pacing phases,",
                 pixels_sent, scores_checked);
        $display("with masked, ignored and bumped-count images; %0d mismatches.", mismatches);
        if (mismatches == 0)
            $display("masked_f1_score_counter regression: pass");
        else
            $display("masked_f1_score_counter regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+sv
sv/mfsc_pkg.sv
sv/masked_f1_score_counter.sv
sv/mfsc_checker.sv
tb/masked_f1_score_counter_test.sv
